>>> hdl/assert_macros.svh
// assertion macros shared by the range maximum engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("range max engine: property violated");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("range max engine: forbidden condition seen");

`else

`define ASSERT_HOLDS(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

>>> hdl/strm_pkg.sv
// shared constants, command codes and state type of the range maximum engine
package strm_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int LEVELS      = 12;
    localparam int VALUE_WIDTH = 32;

    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int LVL_W       = $clog2(LEVELS);
    localparam int LC_W        = $clog2(LEVELS + 1);
    localparam int STORE_DEPTH = MAX_ENTRIES * LEVELS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // command codes of an input item
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QREAD,
        S_QDONE,
        S_BINIT,
        S_BUILD,
        S_DRAIN
    } t_state;

endpackage

>>> hdl/strm_if.sv
// valid/ready channel interfaces for input items and result items
interface strm_in_if import strm_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          last;
    logic        [IDX_W-1:0]       lo_index;
    logic        [IDX_W-1:0]       hi_index;

    modport source (output valid, cmd, value, last, lo_index, hi_index, input ready);
    modport sink   (input valid, cmd, value, last, lo_index, hi_index, output ready);
endinterface

interface strm_out_if import strm_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] max_value;
    logic                          index_error;

    modport source (output valid, max_value, index_error, input ready);
    modport sink   (input valid, max_value, index_error, output ready);
endinterface

>>> hdl/sparse_table_range_max.sv
// range maximum engine over a doubling-span table, built and queried by one sequencer
//
//  channel  | dir | modport | payload
//  ---------+-----+---------+-------------------------------------------
//  i_in     | in  | sink    | cmd, value, last, lo_index, hi_index
//  o_out    | out | source  | max_value, index_error
//
// load: loads are taken back to back while idle; a load with last starts a table
//   build of levels 1 and up, one entry per cycle through the
//   two-read, one-write table memory and the shared signed max unit
// query: accept, table read, compare; an out-of-range query skips the table read
// reset clears control state only; the table memory has no clearing pass
// a finished result sits in the output register; a query that completes while
//   that register is still full holds in its last step until the transfer
`include "assert_macros.svh"

module sparse_table_range_max import strm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    strm_in_if.sink   i_in,
    strm_out_if.source o_out
);

    localparam int P_W   = $clog2(CNT_W + 1);
    localparam int LCX_W = P_W + 1;
    localparam int CMP_W = P_W + LC_W;
    localparam int SUM_W = CNT_W + 1;

    // one-based position of the highest set bit, zero for zero
    function automatic logic [P_W-1:0] bit_len(input logic [CNT_W-1:0] v);
        logic [P_W-1:0] r;
        r = '0;
        for (int k = 0; k < CNT_W; k++) begin
            if (v[k]) r = P_W'(k + 1);
        end
        return r;
    endfunction

    // table word address of entry j at level lvl
    function automatic logic [ADDR_W-1:0] slot(input logic [LVL_W-1:0] lvl,
                                                input logic [IDX_W-1:0] j);
        return ADDR_W'(lvl) * ADDR_W'(MAX_ENTRIES) + ADDR_W'(j);
    endfunction

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_entry_count, n_entry_count;
    logic [LC_W-1:0]  r_level_count, n_level_count;
    logic             r_table_ready, n_table_ready;

    // build sequencer
    logic [LVL_W-1:0]  r_lvl, n_lvl;
    logic [IDX_W-1:0]  r_j, n_j;
    logic [CNT_W-1:0]  r_span, n_span;
    logic              r_wr_en, n_wr_en;
    logic [ADDR_W-1:0] r_wr_addr, n_wr_addr;

    // query operands
    logic [IDX_W-1:0] r_q_lo, n_q_lo;
    logic [IDX_W-1:0] r_q_hi, n_q_hi;
    logic [IDX_W-1:0] r_q_e, n_q_e;
    logic [LVL_W-1:0] r_q_p, n_q_p;
    logic             r_q_err, n_q_err;

    // output register
    logic                          r_out_valid, n_out_valid;
    logic signed [VALUE_WIDTH-1:0] r_out_max, n_out_max;
    logic                          r_out_err, n_out_err;

    // table memory
    logic signed [VALUE_WIDTH-1:0] r_mem [STORE_DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_rd_a, r_rd_b;
    logic                          mem_we, mem_re;
    logic [ADDR_W-1:0]             mem_waddr, mem_raddr_a, mem_raddr_b;
    logic signed [VALUE_WIDTH-1:0] mem_wdata;

    logic signed [VALUE_WIDTH-1:0] max_val;
    logic [CNT_W-1:0]              load_cnt;
    logic                          q_err, q_fwd;
    logic [IDX_W-1:0]              q_diff, q_e;
    logic [P_W-1:0]                q_bits;
    logic [CMP_W-1:0]              q_pc;
    logic [LVL_W-1:0]              q_p;
    logic [CNT_W-1:0]              cnt_m1, half, tail;
    logic [LCX_W-1:0]              lc_raw;
    logic [LC_W-1:0]               lc;
    logic [SUM_W-1:0]              j_plus_d, j_plus_h;
    logic [IDX_W-1:0]              partner;

    // shared signed max unit
    assign max_val = (r_rd_a > r_rd_b) ? r_rd_a : r_rd_b;

    // slot of the next load after a possible restart
    assign load_cnt = r_table_ready ? '0 : r_entry_count;

    // query level and offset from the incoming indexes
    assign q_err  = !r_table_ready
                 || (CNT_W'(i_in.lo_index) >= r_entry_count)
                 || (CNT_W'(i_in.hi_index) >= r_entry_count);
    assign q_fwd  = (i_in.lo_index <= i_in.hi_index);
    assign q_diff = i_in.hi_index - i_in.lo_index;
    assign q_bits = q_fwd ? bit_len(CNT_W'(q_diff)) : '0;
    assign q_e    = (q_bits == '0) ? '0 : (IDX_W'(1) << (q_bits - P_W'(1)));
    assign q_pc   = (CMP_W'(q_bits) >= CMP_W'(r_level_count))
                  ? (CMP_W'(r_level_count) - CMP_W'(1)) : CMP_W'(q_bits);
    assign q_p    = LVL_W'(q_pc);

    // level count from the closed entry count
    assign cnt_m1 = r_entry_count - CNT_W'(1);
    assign lc_raw = LCX_W'(bit_len(cnt_m1)) + LCX_W'(2);
    assign lc     = (lc_raw > LCX_W'(LEVELS)) ? LC_W'(LEVELS) : LC_W'(lc_raw);

    // second operand of a build step, clamped near the table end
    assign half     = r_span >> 1;
    assign j_plus_d = SUM_W'(r_j) + SUM_W'(r_span);
    assign j_plus_h = SUM_W'(r_j) + SUM_W'(half);
    assign tail     = cnt_m1 - half;
    always_comb begin
        if (j_plus_d < SUM_W'(r_entry_count)) begin
            partner = j_plus_d[IDX_W-1:0];
        end else if (j_plus_h >= SUM_W'(r_entry_count)) begin
            partner = r_j;
        end else begin
            partner = tail[IDX_W-1:0];
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.max_value   = r_out_max;
    assign o_out.index_error = r_out_err;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_level_count <= LC_W'(2);
            r_table_ready <= 1'b0;
            r_wr_en       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_entry_count <= n_entry_count;
            r_level_count <= n_level_count;
            r_table_ready <= n_table_ready;
            r_wr_en       <= n_wr_en;
            r_out_valid   <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_lvl     <= n_lvl;
        r_j       <= n_j;
        r_span    <= n_span;
        r_wr_addr <= n_wr_addr;
        r_q_lo    <= n_q_lo;
        r_q_hi    <= n_q_hi;
        r_q_e     <= n_q_e;
        r_q_p     <= n_q_p;
        r_q_err   <= n_q_err;
        r_out_max <= n_out_max;
        r_out_err <= n_out_err;
    end

    // table memory: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_a <= r_mem[mem_raddr_a];
            r_rd_b <= r_mem[mem_raddr_b];
        end
    end

    // sequencer: next state, register updates and memory control
    always_comb begin
        n_state       = r_state;
        n_entry_count = r_entry_count;
        n_level_count = r_level_count;
        n_table_ready = r_table_ready;
        n_lvl         = r_lvl;
        n_j           = r_j;
        n_span        = r_span;
        n_wr_en       = 1'b0;
        n_wr_addr     = r_wr_addr;
        n_q_lo        = r_q_lo;
        n_q_hi        = r_q_hi;
        n_q_e         = r_q_e;
        n_q_p         = r_q_p;
        n_q_err       = r_q_err;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_max     = r_out_max;
        n_out_err     = r_out_err;
        mem_re        = 1'b0;
        mem_raddr_a   = '0;
        mem_raddr_b   = '0;
        // pending build write lands in the cycle after its reads
        mem_we        = r_wr_en;
        mem_waddr     = r_wr_addr;
        mem_wdata     = max_val;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.cmd == CMD_LOAD) begin
                        n_table_ready = 1'b0;
                        n_entry_count = load_cnt;
                        if (load_cnt < CNT_W'(MAX_ENTRIES)) begin
                            mem_we        = 1'b1;
                            mem_waddr     = slot('0, load_cnt[IDX_W-1:0]);
                            mem_wdata     = i_in.value;
                            n_entry_count = load_cnt + CNT_W'(1);
                        end
                        if (i_in.last) begin
                            n_state = S_BINIT;
                        end
                    end else begin
                        n_q_lo  = i_in.lo_index;
                        n_q_hi  = i_in.hi_index;
                        n_q_e   = q_e;
                        n_q_p   = q_p;
                        n_q_err = q_err;
                        n_state = q_err ? S_QDONE : S_QREAD;
                    end
                end
            end
            S_QREAD: begin
                mem_re      = 1'b1;
                mem_raddr_a = slot(r_q_p, r_q_lo);
                mem_raddr_b = slot(r_q_p, r_q_hi - r_q_e);
                n_state     = S_QDONE;
            end
            S_QDONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_max   = r_q_err ? '0 : max_val;
                    n_out_err   = r_q_err;
                    n_state     = S_IDLE;
                end
            end
            S_BINIT: begin
                n_level_count = lc;
                n_lvl         = LVL_W'(1);
                n_j           = '0;
                n_span        = CNT_W'(1);
                if (r_entry_count == '0) begin
                    n_table_ready = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    n_state = S_BUILD;
                end
            end
            S_BUILD: begin
                mem_re      = 1'b1;
                mem_raddr_a = slot(r_lvl - LVL_W'(1), r_j);
                mem_raddr_b = slot(r_lvl - LVL_W'(1), partner);
                n_wr_en     = 1'b1;
                n_wr_addr   = slot(r_lvl, r_j);
                n_j         = r_j + IDX_W'(1);
                if (CNT_W'(r_j) == cnt_m1) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last write of the level lands here before the next level reads it
                if (LC_W'(r_lvl) == r_level_count - LC_W'(1)) begin
                    n_table_ready = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    n_lvl   = r_lvl + LVL_W'(1);
                    n_j     = '0;
                    n_span  = (r_lvl == LVL_W'(1)) ? r_span : (r_span << 1);
                    n_state = S_BUILD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // build writes only happen while the input side is closed
    `ASSERT_NEVER(a_no_build_wr_idle, i_clk, i_rst_n, r_wr_en && i_in.ready)

    // a level being built is always below the level count
    `ASSERT_HOLDS(a_build_lvl_range, i_clk, i_rst_n,
        (r_state == S_BUILD) |-> (LC_W'(r_lvl) < r_level_count))

    // a table only becomes ready at the end of a build
    `ASSERT_HOLDS(a_ready_after_build, i_clk, i_rst_n,
        $rose(r_table_ready) |-> ($past(r_state) == S_DRAIN || $past(r_state) == S_BINIT))

    // a completing query always leaves a result in the output register
    `ASSERT_HOLDS(a_query_result, i_clk, i_rst_n,
        ((r_state == S_QDONE) && (!r_out_valid || o_out.ready)) |=> r_out_valid)

endmodule

>>> verif/sparse_table_range_max_tb.sv
// self-checking testbench of the range maximum engine with a built-in span-table predictor
module sparse_table_range_max_tb import strm_pkg::*; ();

    localparam int CLK_HALF      = 6;
    localparam int RANDOM_ITEMS  = 64;
    localparam int RANDOM_SEQS   = 8;
    localparam int SETTLE_CYCLES = 60;
    localparam int LIMIT_CYCLES  = 1_000_000;

    typedef logic signed [VALUE_WIDTH-1:0] t_word;
    typedef logic        [IDX_W-1:0]       t_idx;

    typedef struct packed {
        t_word max_value;
        logic  index_error;
    } t_range_result;

    logic i_clk;
    logic i_rst_n;

    strm_in_if  in_if ();
    strm_out_if out_if ();

    sparse_table_range_max u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    // predictor copy of the span table and its control state
    t_word span_max [MAX_ENTRIES][LEVELS];
    int    n_entries;
    int    lvl_count;
    bit    table_built;

    t_range_result expected_results [$];
    int            mismatch_count;
    int            items_sent;
    int            src_idle_pct;
    int            sink_stall_pct;

    // clock
    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // hard stop for a hung run
    initial begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("sparse_table_range_max verification failed");
        $finish;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic t_word larger(input t_word a, input t_word b);
        return (a > b) ? a : b;
    endfunction

    // rebuild levels 1 and up over the loaded entries
    function automatic void build_spans();
        int lc;
        int t;
        int d;
        t_word a;
        lc = 2;
        t  = 1;
        d  = 1;
        while (t < n_entries) begin
            lc++;
            t *= 2;
        end
        if (lc > LEVELS) lc = LEVELS;
        lvl_count = lc;
        for (int i = 1; i < lc; i++) begin
            for (int j = 0; j < n_entries; j++) begin
                a = span_max[j][i-1];
                if (j + d < n_entries)
                    span_max[j][i] = larger(a, span_max[j+d][i-1]);
                else if (j + d / 2 >= n_entries)
                    span_max[j][i] = a;
                else
                    span_max[j][i] = larger(a, span_max[n_entries-1-d/2][i-1]);
            end
            // level 2 keeps the unit offset, doubling from there on
            d = (i == 1) ? 1 : d * 2;
        end
    endfunction

    // update table state on an accepted item; queue the result of a query
    function automatic void predict_item(input logic cmd, input t_word value, input logic last,
                                         input t_idx lo, input t_idx hi);
        t_range_result res;
        int lo_i;
        int hi_i;
        int p;
        int e;
        int diff;
        lo_i = lo;
        hi_i = hi;
        if (cmd == CMD_LOAD) begin
            if (table_built) begin
                table_built = 1'b0;
                n_entries   = 0;
            end
            if (n_entries < MAX_ENTRIES) begin
                span_max[n_entries][0] = value;
                n_entries++;
            end
            if (last) begin
                build_spans();
                table_built = 1'b1;
            end
        end else begin
            if (!table_built || lo_i >= n_entries || hi_i >= n_entries) begin
                res.max_value   = '0;
                res.index_error = 1'b1;
            end else begin
                p = 0;
                e = 0;
                if (lo_i <= hi_i) begin
                    diff = hi_i - lo_i;
                    while (diff >= 1) begin
                        diff = diff / 2;
                        e    = (e == 0) ? 1 : e * 2;
                        p++;
                    end
                end
                if (p >= lvl_count) p = lvl_count - 1;
                res.max_value   = larger(span_max[lo_i][p], span_max[hi_i-e][p]);
                res.index_error = 1'b0;
            end
            expected_results.push_back(res);
        end
    endfunction

    // drive one item and wait for its transfer
    task automatic send_item(input logic cmd, input t_word value, input logic last,
                             input t_idx lo, input t_idx hi);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.cmd      <= cmd;
        in_if.value    <= value;
        in_if.last     <= last;
        in_if.lo_index <= lo;
        in_if.hi_index <= hi;
        do @(posedge i_clk); while (!in_if.ready);
        predict_item(cmd, value, last, lo, hi);
        items_sent++;
    endtask

    task automatic send_load(input t_word value, input logic last);
        send_item(CMD_LOAD, value, last, t_idx'($urandom), t_idx'($urandom));
    endtask

    task automatic send_query(input int lo, input int hi);
        send_item(CMD_QUERY, t_word'($urandom), logic'($urandom_range(1)), t_idx'(lo), t_idx'(hi));
    endtask

    // sender holds off until every pending result has come back
    task automatic wait_results_done();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // mostly valid indices, sometimes anywhere in the index field
    function automatic int rand_index(input int n);
        if (n > 0 && $urandom_range(99) < 85) return $urandom_range(n - 1, 0);
        return $urandom_range((1 << IDX_W) - 1, 0);
    endfunction

    // random value, often from a narrow band so ties and near-ties happen
    function automatic t_word rand_value();
        case ($urandom_range(5))
            0: return t_word'($signed($urandom_range(8)) - 4);
            1: return $urandom_range(1) ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                        : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
            default: return t_word'($urandom);
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_range_result exp_res;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result max_value=%0d index_error=%0b",
                         $time, out_if.max_value, out_if.index_error);
                mismatch_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (out_if.max_value !== exp_res.max_value) begin
                    $display("%0t: max_value mismatch expected=%0d actual=%0d",
                             $time, exp_res.max_value, out_if.max_value);
                    mismatch_count++;
                end
                if (out_if.index_error !== exp_res.index_error) begin
                    $display("%0t: index_error mismatch expected=%0b actual=%0b",
                             $time, exp_res.index_error, out_if.index_error);
                    mismatch_count++;
                end
            end
        end
    end

    // queries with no closed table, then a full drain
    task automatic test_query_before_build();
        set_idling(0, 0);
        send_query(0, 0);
        send_query((1 << IDX_W) - 1, (1 << IDX_W) - 1);
        wait_results_done();
    endtask

    // eight entries with both extremes, every query shape
    task automatic test_directed_table();
        t_word vals [8];
        vals = '{-5, {1'b1, {(VALUE_WIDTH-1){1'b0}}}, 17, {1'b0, {(VALUE_WIDTH-1){1'b1}}},
                 -1, 0, 42, {1'b1, {(VALUE_WIDTH-1){1'b0}}}};
        set_idling(0, 0);
        foreach (vals[k]) send_load(vals[k], k == 7);
        send_query(0, 7);
        send_query(0, 2);
        send_query(4, 6);
        send_query(5, 5);
        send_query(7, 7);
        send_query(4, 7);
        // reversed range
        send_query(6, 1);
        // either index past the loaded entries
        send_query(8, 0);
        send_query(0, 8);
        send_query((1 << IDX_W) - 1, (1 << IDX_W) - 1);
    endtask

    // a load after a build starts a new table; single-entry table
    task automatic test_reload_and_single();
        set_idling(0, 72);
        send_load(123, 1'b0);
        send_query(0, 0);
        send_load(-9, 1'b1);
        send_query(0, 1);
        send_query(1, 0);
        send_query(2, 2);
        send_load(rand_value(), 1'b1);
        send_query(0, 0);
        send_query(0, 1);
        wait_results_done();
    endtask

    // fill to capacity, drop extra loads, close on a dropped load
    task automatic test_capacity();
        set_idling(0, 0);
        for (int k = 0; k < MAX_ENTRIES; k++) send_load(t_word'($urandom), 1'b0);
        send_load(t_word'($urandom), 1'b0);
        send_load(t_word'($urandom), 1'b1);
        set_idling(0, 72);
        send_query(0, MAX_ENTRIES - 1);
        send_query(MAX_ENTRIES - 1, MAX_ENTRIES - 1);
        send_query(MAX_ENTRIES - 1, 0);
        send_query(0, 0);
        for (int k = 0; k < 8; k++) send_query(rand_index(MAX_ENTRIES), rand_index(MAX_ENTRIES));
        wait_results_done();
    endtask

    // short load/query sequences mixed with noise, one idling phase per sequence in turn
    task automatic test_random_traffic();
        int start;
        int seq;
        int n;
        int q;
        start = items_sent;
        seq   = 0;
        while (items_sent - start < RANDOM_ITEMS || seq < RANDOM_SEQS) begin
            case (seq % 4)
                0:       set_idling(0, 0);
                1:       set_idling(72, 0);
                2:       set_idling(0, 72);
                default: set_idling(17, 17);
            endcase
            if ($urandom_range(99) < 85) begin
                n = ($urandom_range(99) < 10) ? $urandom_range(40, 17) : $urandom_range(8, 1);
                for (int k = 0; k < n; k++) send_load(rand_value(), k == n - 1);
                q = $urandom_range(8, 3);
                for (int k = 0; k < q; k++) send_query(rand_index(n), rand_index(n));
            end else begin
                n = $urandom_range(6, 1);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(1))
                        send_query(rand_index(8), rand_index(8));
                    else
                        send_load(rand_value(), $urandom_range(99) < 20);
                end
            end
            seq++;
        end
        for (int k = 0; k < 4; k++) send_query(rand_index(8), rand_index(8));
    endtask

    initial begin
        in_if.valid    = 1'b0;
        in_if.cmd      = CMD_LOAD;
        in_if.value    = '0;
        in_if.last     = 1'b0;
        in_if.lo_index = '0;
        in_if.hi_index = '0;
        out_if.ready   = 1'b0;
        i_rst_n        = 1'b0;
        n_entries      = 0;
        lvl_count      = 2;
        table_built    = 1'b0;
        mismatch_count = 0;
        items_sent     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_query_before_build();
        test_directed_table();
        test_reload_and_single();
        test_capacity();
        test_random_traffic();

        // drain, then watch for stray results
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("sparse_table_range_max verification clean");
        else
            $display("sparse_table_range_max verification failed");
        $finish;
    end

endmodule
